@@ rtl/core/fvlb_pkg.sv @@
package fvlb_pkg;

  // Table size and field widths
  localparam int FOG_SAMPLES_DEF = 128;
  localparam int NEAR_W          = 24;
  localparam int INT_W           = 17;
  localparam int IDX_W           = 8;
  localparam int VAL_W           = 18;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 24;
  localparam int Q_W             = 17;

  // Q1.16 one
  localparam logic [INT_W-1:0] ONE_Q16 = 17'd65536;

  // Register reset values
  localparam logic [NEAR_W-1:0] NEAR_RST  = 24'd1280;
  localparam logic [NEAR_W-1:0] FAR_RST   = 24'd3840000;
  localparam logic [INT_W-1:0]  START_RST = 17'd65208;
  localparam logic [INT_W-1:0]  END_RST   = 17'd65536;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_NEAR  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FAR   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_START = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_END   = 2'd3;

endpackage

@@ rtl/core/fog_visibility_lut_builder_unit.sv @@
// Per sample: three 17-step shift-add products, a prep state and a 17-step
// divider, in that order, then the result words.
// Flow: one sample at a time; the next word is taken once all result
// words of the current one have left.
// Reset (synchronous, active high) loads the register defaults and clears
// the previous visibility to zero.
module fog_visibility_lut_builder_unit #(
  parameter int FOG_SAMPLES = fvlb_pkg::FOG_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [fvlb_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [fvlb_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [fvlb_pkg::IDX_W-1:0]            sample_index,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [fvlb_pkg::IDX_W-1:0]            entry_address,
  output logic signed [fvlb_pkg::VAL_W-1:0]     entry_value,
  output logic                                  last_of_item
);

  localparam int SW   = $clog2(FOG_SAMPLES + 1);
  localparam int NSW  = fvlb_pkg::NEAR_W + SW;
  localparam int MPW  = fvlb_pkg::INT_W;
  localparam int PW   = NSW + MPW;
  localparam int NUMW = SW + 44;
  localparam int DW   = SW + 52;
  localparam int IW   = fvlb_pkg::INT_W;
  localparam int VW   = fvlb_pkg::VAL_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_MUL3 = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_OUT1 = 3'd6;
  localparam logic [2:0] ST_OUT2 = 3'd7;

  logic [2:0] state;

  // Configuration registers
  logic [fvlb_pkg::NEAR_W-1:0] near_plane;
  logic [fvlb_pkg::NEAR_W-1:0] far_plane;
  logic [IW-1:0]               start_intensity;
  logic [IW-1:0]               end_intensity;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_plane      <= fvlb_pkg::NEAR_RST;
      far_plane       <= fvlb_pkg::FAR_RST;
      start_intensity <= fvlb_pkg::START_RST;
      end_intensity   <= fvlb_pkg::END_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        fvlb_pkg::REG_NEAR:  near_plane      <= cfg_wdata;
        fvlb_pkg::REG_FAR:   far_plane       <= cfg_wdata;
        fvlb_pkg::REG_START: start_intensity <= cfg_wdata[IW-1:0];
        fvlb_pkg::REG_END:   end_intensity   <= cfg_wdata[IW-1:0];
        default: ;
      endcase
    end
  end

  // Derived magnitudes and signs of the intensity terms
  logic          r_pos;
  logic          r_zero;
  logic [IW-1:0] r_mag;
  logic          d_neg;
  logic [IW-1:0] d_mag;

  assign r_pos  = end_intensity > start_intensity;
  assign r_zero = end_intensity == start_intensity;
  assign r_mag  = r_pos ? end_intensity - start_intensity
                        : start_intensity - end_intensity;
  assign d_neg  = start_intensity > fvlb_pkg::ONE_Q16;
  assign d_mag  = d_neg ? start_intensity - fvlb_pkg::ONE_Q16
                        : fvlb_pkg::ONE_Q16 - start_intensity;

  // Per-sample working registers
  logic [SW-1:0]   idx;
  logic [NSW-1:0]  ns;
  logic [PW-1:0]   t1;
  logic [PW-1:0]   t2;
  logic            mul_start;
  logic            div_start;
  logic            fog_zero;
  logic [DW-1:0]   dividend;
  logic [DW-1:0]   divisor;
  logic [IW-1:0]   prev_vis;
  logic [IW-1:0]   vis;
  logic [VW-1:0]   diff;

  logic [31:0] idx_in;
  logic [SW-1:0] idx_clamp;
  assign idx_in    = 32'(sample_index);
  assign idx_clamp = (idx_in > 32'(FOG_SAMPLES)) ? SW'(FOG_SAMPLES) : SW'(sample_index);

  logic has_vis;
  logic has_diff;
  assign has_vis  = 32'(idx) < 32'(FOG_SAMPLES);
  assign has_diff = idx != '0;

  logic [31:0] diff_addr;
  assign diff_addr = 32'(idx) + 32'(FOG_SAMPLES - 1);

  // Shared shift-add multiplier
  logic [NSW-1:0] mul_mcand;
  logic [MPW-1:0] mul_mplier;
  logic           mul_done;
  logic [PW-1:0]  mul_product;

  always_comb begin
    case (state)
      ST_MUL2: begin
        mul_mcand  = NSW'(near_plane) + NSW'(256);
        mul_mplier = MPW'(idx);
      end
      ST_MUL3: begin
        mul_mcand  = ns;
        mul_mplier = r_mag;
      end
      default: begin
        mul_mcand  = ns;
        mul_mplier = d_mag;
      end
    endcase
  end

  fvlb_serial_mul #(.MCW(NSW), .MPW(MPW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .done    (mul_done),
    .product (mul_product)
  );

  // Numerator and divisor assembly
  logic signed [NUMW-1:0] t1_s;
  logic signed [NUMW-1:0] num;
  logic [NUMW-1:0]        num_mag;
  logic                   num_pos;

  assign t1_s    = d_neg ? -($signed(NUMW'(t1)) <<< 1) : ($signed(NUMW'(t1)) <<< 1);
  assign num     = t1_s - ($signed(NUMW'(t2)) <<< 16);
  assign num_pos = !num[NUMW-1] && (num != '0);
  assign num_mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);

  logic           div_done;
  logic [IW-1:0]  fog_q;
  logic [IW-1:0]  vis_c;

  fvlb_serial_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .result   (fog_q)
  );

  assign vis_c = fvlb_pkg::ONE_Q16 - (fog_zero ? IW'(0) : fog_q);

  assign in_ready = (state == ST_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
      prev_vis  <= '0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state     <= ST_MUL1;
            mul_start <= 1'b1;
          end
        end
        ST_MUL1: begin
          if (mul_done) begin
            state     <= ST_MUL2;
            mul_start <= 1'b1;
          end
        end
        ST_MUL2: begin
          if (mul_done) begin
            state     <= ST_MUL3;
            mul_start <= 1'b1;
          end
        end
        ST_MUL3: begin
          if (mul_done) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          state     <= ST_DIV;
          div_start <= 1'b1;
        end
        ST_DIV: begin
          if (div_done) begin
            state     <= ST_OUT1;
            out_valid <= 1'b1;
            prev_vis  <= vis_c;
          end
        end
        ST_OUT1: begin
          if (out_ready) begin
            if (has_vis && has_diff) begin
              state <= ST_OUT2;
            end else begin
              state     <= ST_IDLE;
              out_valid <= 1'b0;
            end
          end
        end
        ST_OUT2: begin
          if (out_ready) begin
            state     <= ST_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      idx <= idx_clamp;
      ns  <= NSW'(near_plane) * NSW'(FOG_SAMPLES);
    end
    if (state == ST_MUL1 && mul_done) begin
      t1 <= mul_product;
    end
    if (state == ST_MUL2 && mul_done) begin
      t2 <= mul_product;
    end
    if (state == ST_MUL3 && mul_done) begin
      divisor <= (DW'(mul_product) << 8) - DW'(mul_product);
    end
    if (state == ST_PREP) begin
      dividend <= DW'(num_mag) << 7;
      fog_zero <= (near_plane == '0) || (far_plane == '0) || r_zero ||
                  (num == '0) || (num_pos != r_pos);
    end
    if (state == ST_DIV && div_done) begin
      vis  <= vis_c;
      diff <= VW'(vis_c) - VW'(prev_vis);
      if (has_vis) begin
        entry_address <= 8'(idx);
        entry_value   <= $signed(VW'(vis_c));
        last_of_item  <= !has_diff;
      end else begin
        entry_address <= diff_addr[7:0];
        entry_value   <= $signed(VW'(vis_c) - VW'(prev_vis));
        last_of_item  <= 1'b1;
      end
    end
    if (state == ST_OUT1 && out_ready && has_vis && has_diff) begin
      entry_address <= diff_addr[7:0];
      entry_value   <= $signed(diff);
      last_of_item  <= 1'b1;
    end
  end

  // Checks
  a_out_only_in_out_states: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_OUT1 || state == ST_OUT2))
    else $error("result word outside output states");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken while a result word is pending");

  a_second_is_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT2) |-> last_of_item)
    else $error("second word not marked last");

  a_prev_tracks_vis: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT1 && $past(state) == ST_DIV) |-> (prev_vis == vis))
    else $error("previous visibility not updated");

endmodule

@@ rtl/core/fvlb_serial_mul.sv @@
module fvlb_serial_mul #(
  parameter int MCW = 32,
  parameter int MPW = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MCW-1:0]       mcand,
  input  logic [MPW-1:0]       mplier,
  output logic                 done,
  output logic [MCW+MPW-1:0]   product
);

  localparam int PW = MCW + MPW;
  localparam int CW = $clog2(MPW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [PW-1:0] mc;
  logic [MPW-1:0] mp;
  logic [PW-1:0] acc;

  // Control: count one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MPW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift and add
  always_ff @(posedge clk) begin
    if (start) begin
      mc  <= PW'(mcand);
      mp  <= mplier;
      acc <= '0;
    end else if (busy) begin
      if (mp[0]) begin
        acc <= acc + mc;
      end
      mc <= mc << 1;
      mp <= mp >> 1;
    end
  end

  assign product = acc;

endmodule

@@ rtl/core/fvlb_serial_div.sv @@
module fvlb_serial_div #(
  parameter int DW = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [DW-1:0]              divisor,
  output logic                       done,
  output logic [fvlb_pkg::Q_W-1:0]   result
);

  localparam int QW = fvlb_pkg::Q_W;
  localparam int CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          sat;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [QW-1:0] q;
  logic [DW-1:0] rem_sh;
  logic [QW:0]   q_rnd;

  // Control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem_sh = {rem[DW-2:0], 1'b0};

  // Datapath: restoring division, saturate when quotient reaches one
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dvs <= divisor;
      q   <= '0;
      sat <= (dividend >= divisor);
    end else if (busy) begin
      if (rem_sh >= dvs) begin
        rem <= rem_sh - dvs;
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[QW-2:0], 1'b0};
      end
    end
  end

  // Round half up
  assign q_rnd  = ({1'b0, q} + (QW+1)'(1)) >> 1;
  assign result = sat ? fvlb_pkg::ONE_Q16 : q_rnd[QW-1:0];

endmodule

@@ verif/fog_table_checker.sv @@
module fog_table_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [fvlb_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [fvlb_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [fvlb_pkg::IDX_W-1:0]            sample_index,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [fvlb_pkg::IDX_W-1:0]            entry_address,
  input  logic signed [fvlb_pkg::VAL_W-1:0]     entry_value,
  input  logic                                  last_of_item,
  output int                                    fail_count,
  output int                                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fvlb_pkg::*;

  localparam int SAMPLES = FOG_SAMPLES_DEF;

  typedef struct packed {
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] value;
    logic             last;
  } table_entry_t;

  table_entry_t      entry_queue[$];
  logic [NEAR_W-1:0] near_q;
  logic [NEAR_W-1:0] far_q;
  logic [INT_W-1:0]  start_q;
  logic [INT_W-1:0]  end_q;
  logic [INT_W-1:0]  prev_vis;

  assign pending_count = entry_queue.size();

  // Fog density in Q1.16 for one depth sample
  function automatic logic [INT_W-1:0] fog_of_sample(input int unsigned idx);
    longint nn, rr, num;
    logic [127:0] a, b, rem;
    logic [63:0] q;
    nn = longint'(near_q);
    rr = longint'(end_q) - longint'(start_q);
    if (near_q == 0 || far_q == 0 || rr == 0) return '0;
    num = 2 * nn * SAMPLES * (65536 - longint'(start_q))
          - 65536 * longint'(idx) * (nn + 256);
    if (num == 0 || ((num > 0) != (rr > 0))) return '0;
    a = 128'((num > 0) ? num : -num);
    b = 128'(255) * ((rr > 0) ? rr : -rr) * nn * SAMPLES;
    if (128 * a >= b) return ONE_Q16;
    rem = 128 * a;
    q = 0;
    for (int k = 0; k < 17; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= b) begin
        rem = rem - b;
        q[0] = 1'b1;
      end
    end
    return INT_W'((q + 1) >> 1);
  endfunction

  // Queue the visibility and difference words for one sample
  task automatic add_sample_entries(input logic [IDX_W-1:0] raw);
    int unsigned idx;
    logic [31:0] vis, diff;
    table_entry_t e;
    idx = (raw > SAMPLES) ? SAMPLES : raw;
    vis = 32'd65536 - fog_of_sample(idx);
    if (idx < SAMPLES) begin
      e.addr = IDX_W'(idx);
      e.value = VAL_W'(vis);
      e.last = (idx == 0);
      entry_queue.push_back(e);
    end
    if (idx > 0) begin
      diff = vis - prev_vis;
      e.addr = IDX_W'(idx + SAMPLES - 1);
      e.value = VAL_W'(diff);
      e.last = 1'b1;
      entry_queue.push_back(e);
    end
    prev_vis = INT_W'(vis);
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Track registers, predict on accepted words, compare result words
  always @(posedge clk) begin
    table_entry_t exp_e;
    if (rst) begin
      near_q = NEAR_RST;
      far_q = FAR_RST;
      start_q = START_RST;
      end_q = END_RST;
      prev_vis = '0;
      fail_count = 0;
      entry_queue.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_NEAR:  near_q = cfg_wdata;
          REG_FAR:   far_q = cfg_wdata;
          REG_START: start_q = cfg_wdata[INT_W-1:0];
          REG_END:   end_q = cfg_wdata[INT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (entry_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected word addr %0d", entry_address));
        end else begin
          exp_e = entry_queue.pop_front();
          if (entry_address !== exp_e.addr)
            report_mismatch($sformatf("address %0d, want %0d", entry_address, exp_e.addr));
          if (entry_value !== $signed(exp_e.value))
            report_mismatch($sformatf("slot %0d value %0d, want %0d", exp_e.addr,
                                      entry_value, $signed(exp_e.value)));
          if (last_of_item !== exp_e.last)
            report_mismatch($sformatf("slot %0d last %0b, want %0b", exp_e.addr,
                                      last_of_item, exp_e.last));
        end
      end
      if (in_valid && in_ready) add_sample_entries(sample_index);
    end
  end
endmodule

@@ verif/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fvlb_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic [IDX_W-1:0]       sample_index;
  logic                   out_valid;
  logic                   out_ready;
  logic [IDX_W-1:0]       entry_address;
  logic signed [VAL_W-1:0] entry_value;
  logic                   last_of_item;
  int                     fail_count;
  int                     pending_count;
  bit                     calm;

  fog_visibility_lut_builder_unit u_top (.*);

  fog_table_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the result side in bursts
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Send one sample word; caller is at a clock edge
  task automatic send_sample(input logic [IDX_W-1:0] idx);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Mostly in-range indexes, with some beyond the table
  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 255));
    return IDX_W'($urandom_range(0, FOG_SAMPLES_DEF));
  endfunction

  task automatic random_config();
    case ($urandom_range(0, 5))
      0: write_reg(REG_NEAR, 24'hFFFFFF);
      1: write_reg(REG_NEAR, CFG_DATA_W'($urandom_range(1, 4096)));
      default: write_reg(REG_NEAR, CFG_DATA_W'($urandom_range(1, 24'hFFFFFF)));
    endcase
    write_reg(REG_FAR, ($urandom_range(0, 9) == 0) ? 24'd0
                       : CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
    write_reg(REG_START, CFG_DATA_W'($urandom_range(0, 65536)));
    case ($urandom_range(0, 4))
      0: write_reg(REG_END, 24'd65536);
      1: write_reg(REG_END, CFG_DATA_W'($urandom_range(0, 65536)));
      default: write_reg(REG_END, CFG_DATA_W'($urandom_range(0, 131071)));
    endcase
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    sample_index = '0;
    calm = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default table, then edge indexes
    for (int i = 0; i <= FOG_SAMPLES_DEF; i += 16) send_sample(IDX_W'(i));
    send_sample(8'd1);
    send_sample(8'd127);
    send_sample(8'd128);
    send_sample(8'd200);
    send_sample(8'd255);
    drain();
    // Zero near plane, equal intensities, reversed range, full-scale registers, zero far plane
    write_reg(REG_NEAR, 24'd0);
    send_sample(8'd5);
    drain();
    write_reg(REG_NEAR, 24'hFFFFFF);
    write_reg(REG_FAR, 24'hFFFFFF);
    write_reg(REG_START, 24'd1000);
    write_reg(REG_END, 24'd1000);
    send_sample(8'd64);
    drain();
    write_reg(REG_START, 24'd65536);
    write_reg(REG_END, 24'd0);
    send_sample(8'd0);
    send_sample(8'd128);
    drain();
    write_reg(REG_START, 24'd0);
    write_reg(REG_END, 24'h1FFFF);
    write_reg(REG_NEAR, 24'd1);
    write_reg(REG_FAR, 24'd0);
    send_sample(8'd10);
    drain();
    write_reg(REG_FAR, 24'd1);
    send_sample(8'd0);
    send_sample(8'd64);
    drain();

    // Random phases: full table sweeps and random indexes in turn, each under a random setting
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      if (ph >= 10) calm = 1'b1;
      if (ph % 2 == 0) begin
        for (int i = 0; i <= FOG_SAMPLES_DEF; i++) send_sample(IDX_W'(i));
      end else begin
        repeat (60) send_sample(pick_index());
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
